// ===== rtl/core/tcce_pkg.sv =====
// Shared types, constants and cell-position helpers for the text console cell engine.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

   localparam int MAX_COLS_DEF        = 128;
   localparam int MAX_ROWS_DEF        = 64;
   localparam int WRITE_COL_LIMIT_DEF = 80;
   localparam int DEF_COLUMNS         = 80;
   localparam int DEF_ROWS            = 25;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_FIRST   = 8'h20;
   localparam logic [7:0] CH_LAST    = 8'h7E;

   localparam logic [2:0] OP_PRINT  = 3'd0;
   localparam logic [2:0] OP_SET    = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [2:0] CMD_PRINT  = 3'd0;
   localparam logic [2:0] CMD_SET    = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;
   localparam logic [2:0] CMD_NOP    = 3'd5;

   localparam int          CSR_AW      = 3;
   localparam logic        CSR_COLUMNS = 1'b0;
   localparam logic        CSR_ROWS    = 1'b1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  ch;
      logic [7:0]  colour;
      logic [6:0]  col;
      logic [15:0] row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [15:0] cursor_row;
      logic [15:0] scroll_offset;
      logic [6:0]  dirty_start_col;
      logic [15:0] dirty_start_row;
      logic [6:0]  dirty_end_col;
      logic [15:0] dirty_end_row;
      logic        repaint;
      logic [15:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        printable;
      logic        newline;
      logic [7:0]  ch;
      logic [7:0]  colour;
      logic [6:0]  col;
      logic [15:0] row;
   } cmd_type;

   typedef struct packed {
      logic [15:0] r;
      logic [6:0]  c;
   } pt_type;

   typedef struct packed {
      pt_type s;
      pt_type e;
   } span_type;

   function automatic pt_type pt_next(input pt_type p, input logic [7:0] columns);
      pt_type q;
      if ((8'(p.c) + 8'd1) >= columns) begin
         q.c = 7'd0;
         q.r = p.r + 16'd1;
      end else begin
         q.c = p.c + 7'd1;
         q.r = p.r;
      end
      return q;
   endfunction

   function automatic logic pt_lt(input pt_type p, input pt_type q);
      if (p.r == q.r) return p.c < q.c;
      return p.r < q.r;
   endfunction

   // Grow the dirty span out to one cell; an empty span becomes that cell alone.
   function automatic span_type span_add(input span_type sp, input pt_type p,
                                         input logic [7:0] columns);
      span_type o;
      o = sp;
      if (sp.s == sp.e) begin
         o.s = p;
         o.e = pt_next(p, columns);
      end else if (pt_lt(p, sp.s)) begin
         o.s = p;
      end else if (pt_lt(sp.e, p)) begin
         o.e = p;
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tcce_front.sv =====
// Front end: accepts requests, classifies them into commands and holds them in a
// two-entry queue for the back end. Depends on tcce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcce_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  tcce_pkg::req_type  req_payload,
   output logic               cmd_valid,
   input  wire                cmd_pop,
   output tcce_pkg::cmd_type  cmd
);
   import tcce_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cls;
   logic       push;

   always_comb begin
      cls.printable = (req_payload.ch >= CH_FIRST) && (req_payload.ch <= CH_LAST);
      cls.newline   = (req_payload.ch == CH_NEWLINE);
      cls.ch        = req_payload.ch;
      cls.colour    = req_payload.colour;
      cls.col       = req_payload.col;
      cls.row       = req_payload.row;
      unique case (req_payload.operation)
         OP_PRINT:  cls.kind = CMD_PRINT;
         OP_SET:    cls.kind = CMD_SET;
         OP_DELETE: cls.kind = CMD_DELETE;
         OP_READ:   cls.kind = CMD_READ;
         OP_CLEAR:  cls.kind = CMD_CLEAR;
         default:   cls.kind = CMD_NOP;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= cls;
   end

endmodule
`default_nettype wire

// ===== rtl/core/tcce_div.sv =====
// Bit-serial restoring divider that returns the remainder of a 16-bit row number
// by the row count, one quotient bit per cycle. Depends on tcce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcce_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [15:0] dividend,
   input  wire  [6:0]  divisor,
   output logic        done,
   output logic [6:0]  remainder
);
   import tcce_pkg::*;

   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic        done_ff, done_in;
   logic [7:0]  trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[15]};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = 5'd16;
         quo_in = dividend;
         rem_in = 7'd0;
      end else if (cnt_ff != 5'd0) begin
         quo_in = {quo_ff[14:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = 7'(trial - {1'b0, divisor});
         else                          rem_in = trial[6:0];
         cnt_in  = cnt_ff - 5'd1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tcce_back.sv =====
// Back end: sequencer that carries out commands on the cell memory, cursor,
// scroll offset and dirty span, and holds the response register. Depends on
// tcce_pkg and tcce_div.
`timescale 1ns / 1ps
`default_nettype none
module tcce_back #(
   parameter int MAX_COLS        = tcce_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS        = tcce_pkg::MAX_ROWS_DEF,
   parameter int WRITE_COL_LIMIT = tcce_pkg::WRITE_COL_LIMIT_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire  [7:0]         columns,
   input  wire  [6:0]         rows,
   input  wire                cmd_valid,
   output logic               cmd_pop,
   input  tcce_pkg::cmd_type  cmd,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output tcce_pkg::rsp_type  rsp_payload
);
   import tcce_pkg::*;

   localparam int MEM_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int LW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ROWS_RST  = (DEF_ROWS > MAX_ROWS) ? MAX_ROWS : DEF_ROWS;

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_BASE   = 4'd3;
   localparam logic [3:0] ST_ACCESS = 4'd4;
   localparam logic [3:0] ST_MOVE1  = 4'd5;
   localparam logic [3:0] ST_MOVE2  = 4'd6;
   localparam logic [3:0] ST_SCHK   = 4'd7;
   localparam logic [3:0] ST_CDIV   = 4'd8;
   localparam logic [3:0] ST_CBASE  = 4'd9;
   localparam logic [3:0] ST_CLR    = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   logic [3:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   pt_type        cur_ff, cur_in;
   pt_type        tgt_ff, tgt_in;
   logic [15:0]   top_ff, top_in;
   span_type      span_ff, span_in;
   span_type      old_span_ff, old_span_in;
   logic [LW-1:0] line_ff, line_in;
   logic [AW-1:0] base_ff, base_in;
   logic [6:0]    col_ff, col_in;
   logic [7:0]    clr_col_ff, clr_col_in;
   logic [6:0]    clr_left_ff, clr_left_in;
   logic [15:0]   clr_abs_ff, clr_abs_in;
   logic [AW-1:0] init_cnt_ff, init_cnt_in;
   logic          rd_hit_ff, rd_hit_in;
   logic          div_go_ff, div_go_in;
   logic [15:0]   div_arg_ff, div_arg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [15:0]   cell_mem [MEM_DEPTH];
   logic [15:0]   rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [15:0]   mem_wdata;

   logic          div_done;
   logic [6:0]    div_rem;
   logic          store_ok, rsp_load;
   logic [15:0]   row_gap, n_scroll;
   logic [6:0]    lim;
   pt_type        p_req;

   tcce_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_arg_ff),
      .divisor   (rows),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign store_ok = cmd_ff.printable && (9'(cur_ff.c) < 9'(WRITE_COL_LIMIT)) &&
                     (8'(cur_ff.c) < columns);
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign row_gap  = cur_ff.r - top_ff;
   assign n_scroll = row_gap - 16'(rows) + 16'd1;
   assign lim      = (n_scroll < 16'(rows)) ? n_scroll[6:0] : rows;
   assign p_req    = '{r: cmd_ff.row, c: cmd_ff.col};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      top_in       = top_ff;
      span_in      = span_ff;
      old_span_in  = old_span_ff;
      line_in      = line_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      clr_col_in   = clr_col_ff;
      clr_left_in  = clr_left_ff;
      clr_abs_in   = clr_abs_ff;
      init_cnt_in  = init_cnt_ff;
      rd_hit_in    = rd_hit_ff;
      div_go_in    = 1'b0;
      div_arg_in   = div_arg_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = base_ff + AW'(col_ff);
      mem_wdata    = 16'd0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_INIT: begin
            mem_we      = 1'b1;
            mem_addr    = init_cnt_ff;
            init_cnt_in = init_cnt_ff + AW'(1);
            if (init_cnt_ff == AW'(MEM_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               old_span_in = span_ff;
               rd_hit_in   = 1'b0;
               case (cmd.kind)
                  CMD_PRINT: begin
                     div_go_in  = 1'b1;
                     div_arg_in = cur_ff.r;
                     col_in     = cur_ff.c;
                     state_in   = ST_DIV;
                  end
                  CMD_SET: begin
                     tgt_in   = '{r: cmd.row, c: cmd.col};
                     state_in = ST_MOVE1;
                  end
                  CMD_DELETE, CMD_READ: begin
                     if (8'(cmd.col) < columns) begin
                        div_go_in  = 1'b1;
                        div_arg_in = cmd.row;
                        col_in     = cmd.col;
                        state_in   = ST_DIV;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  CMD_CLEAR: begin
                     span_in.e = span_ff.s;
                     state_in  = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               line_in  = LW'(div_rem);
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            base_in  = AW'(line_ff * columns);
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            case (cmd_ff.kind)
               CMD_PRINT: begin
                  mem_we    = store_ok;
                  mem_wdata = {cmd_ff.colour, cmd_ff.ch};
                  if (store_ok) span_in = span_add(span_ff, cur_ff, columns);
                  if (cmd_ff.newline) tgt_in = '{r: cur_ff.r + 16'd1, c: 7'd0};
                  else                tgt_in = pt_next(cur_ff, columns);
                  state_in = ST_MOVE1;
               end
               CMD_DELETE: begin
                  mem_we   = 1'b1;
                  span_in  = span_add(span_ff, p_req, columns);
                  state_in = ST_OUT;
               end
               default: begin
                  mem_re    = 1'b1;
                  rd_hit_in = 1'b1;
                  state_in  = ST_OUT;
               end
            endcase
         end
         ST_MOVE1: begin
            span_in  = span_add(span_ff, cur_ff, columns);
            state_in = ST_MOVE2;
         end
         ST_MOVE2: begin
            cur_in   = tgt_ff;
            span_in  = span_add(span_ff, tgt_ff, columns);
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            // A negative distance never scrolls; otherwise all scrolls land at once.
            if (row_gap[15] || (row_gap < 16'(rows))) begin
               state_in = ST_OUT;
            end else begin
               clr_left_in = lim;
               clr_abs_in  = top_ff + 16'(rows);
               div_go_in   = 1'b1;
               div_arg_in  = top_ff + 16'(rows);
               top_in      = top_ff + n_scroll;
               span_in.s   = '{r: top_ff + n_scroll, c: 7'd0};
               span_in.e   = '{r: top_ff + n_scroll + 16'(rows), c: 7'd0};
               state_in    = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_done) begin
               line_in    = LW'(div_rem);
               clr_col_in = 8'd0;
               state_in   = ST_CBASE;
            end
         end
         ST_CBASE: begin
            base_in    = AW'(line_ff * columns);
            clr_col_in = 8'd0;
            state_in   = ST_CLR;
         end
         ST_CLR: begin
            mem_we   = 1'b1;
            mem_addr = base_ff + AW'(clr_col_ff);
            if (clr_col_ff == columns - 8'd1) begin
               if (clr_left_ff == 7'd1) begin
                  state_in = ST_OUT;
               end else begin
                  clr_left_in = clr_left_ff - 7'd1;
                  clr_abs_in  = clr_abs_ff + 16'd1;
                  // The store line wraps to zero with the row number or at the row count.
                  if (clr_abs_ff == 16'hFFFF)                  line_in = '0;
                  else if (9'(line_ff) + 9'd1 == 9'(rows))     line_in = '0;
                  else                                         line_in = line_ff + LW'(1);
                  state_in = ST_CBASE;
               end
            end else begin
               clr_col_in = clr_col_ff + 8'd1;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in           = 1'b1;
               rsp_in.cursor_col      = cur_ff.c;
               rsp_in.cursor_row      = cur_ff.r;
               rsp_in.scroll_offset   = top_ff;
               rsp_in.dirty_start_col = span_ff.s.c;
               rsp_in.dirty_start_row = span_ff.s.r;
               rsp_in.dirty_end_col   = span_ff.e.c;
               rsp_in.dirty_end_row   = span_ff.e.r;
               rsp_in.repaint         = (span_ff != old_span_ff);
               rsp_in.cell_value      = rd_hit_ff ? rdata_ff : 16'd0;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         cur_ff       <= '0;
         top_ff       <= 16'd0;
         span_ff.s    <= '0;
         span_ff.e    <= '{r: 16'(ROWS_RST), c: 7'd0};
         rd_hit_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         cur_ff       <= cur_in;
         top_ff       <= top_in;
         span_ff      <= span_in;
         rd_hit_ff    <= rd_hit_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tgt_ff      <= tgt_in;
      old_span_ff <= old_span_in;
      line_ff     <= line_in;
      base_ff     <= base_in;
      col_ff      <= col_in;
      clr_col_ff  <= clr_col_in;
      clr_left_ff <= clr_left_in;
      clr_abs_ff  <= clr_abs_in;
      div_arg_ff  <= div_arg_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_addr] <= mem_wdata;
      if (mem_re) rdata_ff <= cell_mem[mem_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/text_console_cell_engine.sv =====
// Text console cell engine: clear span and unknown codes respond directly; delete and read
// (column in range) and print map the row to a store line by a serial remainder step, form
// the line base and access the cell; set cursor and print move the cursor and check for a
// scroll, which adds a remainder step and clears each new line, one cell write per cycle on
// the single memory port. The request queue is registered in front; responses leave from a
// register; one at a time. After reset the MAX_COLS*MAX_ROWS cells (8192 by default) are
// zeroed before the first request is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cell_engine #(
   parameter int MAX_COLS        = tcce_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS        = tcce_pkg::MAX_ROWS_DEF,
   parameter int WRITE_COL_LIMIT = tcce_pkg::WRITE_COL_LIMIT_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  tcce_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output tcce_pkg::rsp_type            rsp_payload,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [tcce_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire  [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import tcce_pkg::*;

   localparam int COLS_RST = (DEF_COLUMNS > MAX_COLS) ? MAX_COLS : DEF_COLUMNS;
   localparam int ROWS_RST = (DEF_ROWS > MAX_ROWS) ? MAX_ROWS : DEF_ROWS;

   logic [7:0] columns_ff, columns_in;
   logic [6:0] rows_ff, rows_in;
   logic       csr_wr;
   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_ROWS) ? 32'(rows_ff) : 32'(columns_ff);

   // Written values are held within 1..MAX_COLS and 1..MAX_ROWS.
   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_COLUMNS: begin
               if (csr_pwdata[7:0] == 8'd0)                  columns_in = 8'd1;
               else if (9'(csr_pwdata[7:0]) > 9'(MAX_COLS))  columns_in = 8'(MAX_COLS);
               else                                          columns_in = csr_pwdata[7:0];
            end
            default: begin
               if (csr_pwdata[6:0] == 7'd0)                  rows_in = 7'd1;
               else if (9'(csr_pwdata[6:0]) > 9'(MAX_ROWS))  rows_in = 7'(MAX_ROWS);
               else                                          rows_in = csr_pwdata[6:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 8'(COLS_RST);
         rows_ff    <= 7'(ROWS_RST);
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   tcce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd)
   );

   tcce_back #(
      .MAX_COLS        (MAX_COLS),
      .MAX_ROWS        (MAX_ROWS),
      .WRITE_COL_LIMIT (WRITE_COL_LIMIT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .columns     (columns_ff),
      .rows        (rows_ff),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the text console cell engine: random and directed requests,
// an internal predictor of the cell store, cursor, scroll offset and dirty span.
// Depends on rtl/core/tcce_pkg.sv and rtl/core/text_console_cell_engine.sv.
`timescale 1ns / 1ps
module tb;
   import tcce_pkg::*;

   localparam logic [2:0] ADDR_COLUMNS = 3'd0;
   localparam logic [2:0] ADDR_ROWS    = 3'd4;
   localparam logic [2:0] OP_TOP_CODE  = 3'd7;
   localparam int         STORE_DEPTH  = MAX_COLS_DEF * MAX_ROWS_DEF;
   localparam int         NUM_PHASES   = 8;
   localparam int         PHASE_ITEMS  = 141;

   typedef struct {
      req_type q;
      bit      hold;
   } pending_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   text_console_cell_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Console state as the predictor sees it.
   logic [15:0] cells [0:STORE_DEPTH-1];
   int unsigned n_cols, n_rows;
   logic [6:0]  cur_c;
   logic [15:0] cur_r, top_r;
   pt_type      span_s, span_e;

   pending_type pending_reqs[$];
   rsp_type     expected_rsps[$];
   bit          req_taken = 1'b0;
   int          send_idle_pct = 13;
   int          recv_idle_pct = 82;
   int          mismatches = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("** text_console_cell_engine: FAILED **");
      $finish;
   end

   function automatic pt_type next_cell(pt_type p);
      pt_type q;
      if (int'(p.c) + 1 >= int'(n_cols)) begin
         q.c = 7'd0;
         q.r = p.r + 16'd1;
      end else begin
         q.c = p.c + 7'd1;
         q.r = p.r;
      end
      return q;
   endfunction

   function automatic bit precedes(pt_type a, pt_type b);
      if (a.r == b.r) return a.c < b.c;
      return a.r < b.r;
   endfunction

   function automatic void mark_cell(pt_type p);
      if (span_s == span_e) begin
         span_s = p;
         span_e = next_cell(p);
      end else if (precedes(p, span_s)) begin
         span_s = p;
      end else if (precedes(span_e, p)) begin
         span_e = p;
      end
   endfunction

   function automatic int cell_addr(logic [6:0] c, logic [15:0] r);
      return int'(c) + (int'(r) % int'(n_rows)) * int'(n_cols);
   endfunction

   function automatic void blank_line(logic [15:0] absrow);
      int base;
      base = (int'(absrow) % int'(n_rows)) * int'(n_cols);
      for (int i = 0; i < int'(n_cols); i++) cells[base + i] = 16'd0;
   endfunction

   function automatic void move_cursor_to(logic [6:0] c, logic [15:0] r);
      pt_type p;
      logic [15:0] gap;
      int n, lim;
      p.c = cur_c;
      p.r = cur_r;
      mark_cell(p);
      cur_c = c;
      cur_r = r;
      p.c = cur_c;
      p.r = cur_r;
      mark_cell(p);
      gap = cur_r - top_r;
      if (gap[15] || int'(gap) < int'(n_rows)) return;
      n = int'(gap) - int'(n_rows) + 1;
      lim = (n < int'(n_rows)) ? n : int'(n_rows);
      for (int k = 0; k < lim; k++) blank_line(top_r + 16'(n_rows) + 16'(k));
      top_r = top_r + 16'(n);
      span_s.c = 7'd0;
      span_s.r = top_r;
      span_e.c = 7'd0;
      span_e.r = top_r + 16'(n_rows);
   endfunction

   function automatic rsp_type console_outcome(req_type q);
      rsp_type o;
      pt_type old_s, old_e, p;
      old_s = span_s;
      old_e = span_e;
      o = '0;
      case (q.operation)
         OP_PRINT: begin
            if (q.ch >= CH_FIRST && q.ch <= CH_LAST && int'(cur_c) < WRITE_COL_LIMIT_DEF
                && int'(cur_c) < int'(n_cols)) begin
               cells[cell_addr(cur_c, cur_r)] = {q.colour, q.ch};
               p.c = cur_c;
               p.r = cur_r;
               mark_cell(p);
            end
            if (q.ch == CH_NEWLINE) begin
               move_cursor_to(7'd0, cur_r + 16'd1);
            end else begin
               p.c = cur_c;
               p.r = cur_r;
               p = next_cell(p);
               move_cursor_to(p.c, p.r);
            end
         end
         OP_SET: move_cursor_to(q.col, q.row);
         OP_DELETE: begin
            if (int'(q.col) < int'(n_cols)) begin
               cells[cell_addr(q.col, q.row)] = 16'd0;
               p.c = q.col;
               p.r = q.row;
               mark_cell(p);
            end
         end
         OP_READ: begin
            if (int'(q.col) < int'(n_cols)) o.cell_value = cells[cell_addr(q.col, q.row)];
         end
         OP_CLEAR: span_e = span_s;
         default: ;
      endcase
      o.cursor_col      = cur_c;
      o.cursor_row      = cur_r;
      o.scroll_offset   = top_r;
      o.dirty_start_col = span_s.c;
      o.dirty_start_row = span_s.r;
      o.dirty_end_col   = span_e.c;
      o.dirty_end_row   = span_e.r;
      o.repaint         = (old_s != span_s) || (old_e != span_e);
      return o;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Results are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $time, rsp_payload);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_payload.cursor_col));
               check_field("cursor_row", want.cursor_row, rsp_payload.cursor_row);
               check_field("scroll_offset", want.scroll_offset, rsp_payload.scroll_offset);
               check_field("dirty_start_col", 16'(want.dirty_start_col),
                           16'(rsp_payload.dirty_start_col));
               check_field("dirty_start_row", want.dirty_start_row,
                           rsp_payload.dirty_start_row);
               check_field("dirty_end_col", 16'(want.dirty_end_col),
                           16'(rsp_payload.dirty_end_col));
               check_field("dirty_end_row", want.dirty_end_row, rsp_payload.dirty_end_row);
               check_field("repaint", 16'(want.repaint), 16'(rsp_payload.repaint));
               check_field("cell_value", want.cell_value, rsp_payload.cell_value);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(console_outcome(req_payload));
            req_taken = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                (!pending_reqs[0].hold || expected_rsps.size() == 0)) begin
               req_payload <= pending_reqs[0].q;
               req_valid   <= 1'b1;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      int unsigned v;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_COLUMNS) begin
         v = value & 32'hFF;
         n_cols = (v < 1) ? 1 : (v > MAX_COLS_DEF) ? MAX_COLS_DEF : v;
      end else begin
         v = value & 32'h7F;
         n_rows = (v < 1) ? 1 : (v > MAX_ROWS_DEF) ? MAX_ROWS_DEF : v;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic queue_req(logic [2:0] op, logic [7:0] ch, logic [7:0] colour,
                            logic [6:0] col, logic [15:0] row, bit hold = 1'b0);
      pending_type e;
      e.q.operation = op;
      e.q.ch        = ch;
      e.q.colour    = colour;
      e.q.col       = col;
      e.q.row       = row;
      e.hold        = hold;
      pending_reqs.push_back(e);
   endtask

   // Rows are drawn around the visible window so that cells written earlier are read back.
   function automatic logic [15:0] near_row();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return top_r + 16'($urandom_range(0, n_rows + 3)) - 16'd3;
   endfunction

   function automatic logic [6:0] pick_col();
      if ($urandom_range(9) < 7) return 7'($urandom_range(0, n_cols));
      return 7'($urandom);
   endfunction

   task automatic queue_random(int count, int hold_at);
      int pick;
      logic [7:0] ch;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            case ($urandom_range(19))
               0, 1, 2:    ch = CH_NEWLINE;
               3, 4, 5, 6: ch = 8'($urandom);
               default:    ch = 8'($urandom_range(CH_FIRST, CH_LAST));
            endcase
            queue_req(OP_PRINT, ch, 8'($urandom), 7'($urandom), 16'($urandom), i == hold_at);
         end else if (pick < 60)
            queue_req(OP_SET, 8'($urandom), 8'($urandom), pick_col(), near_row(), i == hold_at);
         else if (pick < 72)
            queue_req(OP_DELETE, 8'($urandom), 8'($urandom), pick_col(),
                      ($urandom_range(1)) ? near_row() : 16'($urandom), i == hold_at);
         else if (pick < 87)
            queue_req(OP_READ, 8'($urandom), 8'($urandom), pick_col(),
                      ($urandom_range(1)) ? near_row() : 16'($urandom), i == hold_at);
         else if (pick < 95)
            queue_req(OP_CLEAR, 8'($urandom), 8'($urandom), 7'($urandom), 16'($urandom),
                      i == hold_at);
         else
            queue_req(3'($urandom_range(CMD_NOP, OP_TOP_CODE)), 8'($urandom), 8'($urandom),
                      7'($urandom), 16'($urandom), i == hold_at);
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   int phase_cols [NUM_PHASES] = '{80, 80, 1, 128, 0, 255, 40, 200};
   int phase_rows [NUM_PHASES] = '{25, 25, 1, 64, 127, 3, 10, 0};

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) cells[i] = 16'd0;
      n_cols = DEF_COLUMNS;
      n_rows = DEF_ROWS;
      cur_c  = 7'd0;
      cur_r  = 16'd0;
      top_r  = 16'd0;
      span_s = '0;
      span_e.c = 7'd0;
      span_e.r = 16'(DEF_ROWS);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening at the reset geometry.
      queue_req(OP_PRINT, "A", 8'hFF, 7'd0, 16'd0);
      queue_req(OP_PRINT, CH_FIRST, 8'h00, 7'd0, 16'd0);
      queue_req(OP_PRINT, CH_LAST, 8'h5A, 7'd0, 16'd0);
      queue_req(OP_PRINT, 8'h1F, 8'hA5, 7'd0, 16'd0);
      queue_req(OP_PRINT, 8'h7F, 8'h11, 7'd0, 16'd0);
      queue_req(OP_PRINT, 8'hFF, 8'hFF, 7'd0, 16'd0);
      queue_req(OP_PRINT, CH_NEWLINE, 8'h00, 7'd0, 16'd0);
      queue_req(OP_READ, 8'h00, 8'h00, 7'd0, 16'd0);
      queue_req(OP_READ, 8'h00, 8'h00, 7'd127, 16'd0);
      queue_req(OP_DELETE, 8'h00, 8'h00, 7'd1, 16'd0);
      queue_req(OP_DELETE, 8'h00, 8'h00, 7'd127, 16'd0);
      queue_req(OP_READ, 8'h00, 8'h00, 7'd1, 16'd0);
      queue_req(OP_CLEAR, 8'h00, 8'h00, 7'd0, 16'd0);
      queue_req(OP_SET, 8'h00, 8'h00, 7'd79, 16'd2);
      queue_req(OP_PRINT, "z", 8'h80, 7'd0, 16'd0);
      queue_req(OP_SET, 8'h00, 8'h00, 7'd100, 16'd3);
      queue_req(OP_PRINT, "q", 8'h01, 7'd0, 16'd0);
      queue_req(OP_SET, 8'h00, 8'h00, 7'd5, 16'd24);
      queue_req(OP_PRINT, CH_NEWLINE, 8'h00, 7'd0, 16'd0);
      queue_req(OP_SET, 8'h00, 8'h00, 7'd0, 16'hFFFF);
      queue_req(OP_SET, 8'h00, 8'h00, 7'd3, 16'h7FFF);
      queue_req(CMD_NOP, 8'hFF, 8'hFF, 7'd127, 16'hFFFF);
      queue_req(OP_TOP_CODE, 8'h00, 8'h00, 7'd0, 16'd0);
      queue_req(OP_READ, 8'h00, 8'h00, 7'd0, 16'hFFFF);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         write_csr(ADDR_COLUMNS, 32'(phase_cols[ph]));
         write_csr(ADDR_ROWS, 32'(phase_rows[ph]));
         if (ph < 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 82;
         end else if (ph < 6) begin
            send_idle_pct = 82;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // In one phase the sender holds back until every response is in.
         queue_random(PHASE_ITEMS, (ph == 4) ? PHASE_ITEMS / 2 : -1);
      end
      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("** text_console_cell_engine: PASSED **");
      else
         $display("** text_console_cell_engine: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_front.sv
rtl/core/tcce_div.sv
rtl/core/tcce_back.sv
rtl/core/text_console_cell_engine.sv
sim/tb.sv
